// ===== rtl/rthsv_pkg.sv =====
// shared types and constants for the rgb to hsv conversion pipeline
`default_nettype none

package rthsv_pkg;

   localparam int CHAN_BITS = 8;
   localparam int HUE_BITS  = 15;
   localparam int SAT_BITS  = 8;
   localparam int DVS_BITS  = CHAN_BITS + 1;
   localparam int QUO_BITS  = HUE_BITS;
   localparam int NUM_BITS  = QUO_BITS + DVS_BITS;
   localparam int SUM_BITS  = CHAN_BITS + 4;
   localparam int CELL_COUNT = QUO_BITS;

   localparam logic [HUE_BITS-1:0] HUE_FULL = HUE_BITS'(23040);
   localparam int HUE_STEP2 = 7680;
   localparam int SAT_SCALE2 = 510;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } rthsv_req_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]  hue;
      logic [SAT_BITS-1:0]  saturation;
      logic [CHAN_BITS-1:0] value;
   } rthsv_rsp_type;

   typedef struct packed {
      logic [DVS_BITS-1:0] rem;
      logic [QUO_BITS-1:0] numq;
      logic [DVS_BITS-1:0] dvs;
   } rthsv_lane_type;

   typedef struct packed {
      rthsv_lane_type       hue;
      rthsv_lane_type       sat;
      logic [CHAN_BITS-1:0] value;
   } rthsv_cell_type;

endpackage

`default_nettype wire

// ===== rtl/rthsv_front.sv =====
// front stage: max and min selection, sector offset and divider operand setup
`default_nettype none

module rthsv_front
   import rthsv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           in_valid,
   input  wire rthsv_req_type  in_item,
   output logic                out_valid,
   output rthsv_cell_type      out_data
);

   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } sel_type;

   logic [CHAN_BITS-1:0] r, g, b, mx, mn, d;
   sel_type              hi_sel;
   logic signed [SUM_BITS-1:0] x, xa;
   logic [NUM_BITS-1:0]  hue_num, sat_num;
   rthsv_cell_type       data_in;
   logic                 valid_ff;
   rthsv_cell_type       data_ff;

   always_comb begin
      r = in_item.red;
      g = in_item.green;
      b = in_item.blue;
      hi_sel = (r >= g) ? SEL_RED : SEL_GREEN;
      mx = (r >= g) ? r : g;
      if (!(mx >= b)) begin
         hi_sel = SEL_BLUE;
         mx = b;
      end
      mn = (r <= g) ? r : g;
      if (!(mn <= b)) begin
         mn = b;
      end
      d = mx - mn;

      unique case (hi_sel)
         SEL_RED: begin
            x = $signed(SUM_BITS'(g)) - $signed(SUM_BITS'(b));
         end
         SEL_GREEN: begin
            x = $signed(SUM_BITS'({d, 1'b0})) + $signed(SUM_BITS'(b))
                - $signed(SUM_BITS'(r));
         end
         SEL_BLUE: begin
            x = $signed(SUM_BITS'({d, 2'b00})) + $signed(SUM_BITS'(r))
                - $signed(SUM_BITS'(g));
         end
         default: begin
            x = '0;
         end
      endcase

      // wrap negative hue by adding six sectors
      if (x < 0) begin
         xa = x + $signed(SUM_BITS'({d, 2'b00})) + $signed(SUM_BITS'({d, 1'b0}));
      end else begin
         xa = x;
      end

      hue_num = NUM_BITS'(unsigned'(xa)) * NUM_BITS'(HUE_STEP2) + NUM_BITS'(d);
      sat_num = NUM_BITS'(d) * NUM_BITS'(SAT_SCALE2) + NUM_BITS'(mx);

      // grey pixel: hue numerator is zero, keep divisor nonzero
      data_in.hue.rem  = hue_num[NUM_BITS-1:QUO_BITS];
      data_in.hue.numq = hue_num[QUO_BITS-1:0];
      data_in.hue.dvs  = (d == '0) ? DVS_BITS'(1) : {d, 1'b0};
      // black pixel: saturation numerator is zero, keep divisor nonzero
      data_in.sat.rem  = sat_num[NUM_BITS-1:QUO_BITS];
      data_in.sat.numq = sat_num[QUO_BITS-1:0];
      data_in.sat.dvs  = (mx == '0) ? DVS_BITS'(1) : {mx, 1'b0};
      data_in.value    = mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/rthsv_div_cell.sv =====
// divider cell: one restoring quotient bit for the hue and saturation lanes
`default_nettype none

module rthsv_div_cell
   import rthsv_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire rthsv_cell_type  in_data,
   output logic                 out_valid,
   output rthsv_cell_type       out_data
);

   function automatic rthsv_lane_type div_step(input rthsv_lane_type lane);
      rthsv_lane_type  res;
      logic [DVS_BITS:0] t;
      t   = {lane.rem, lane.numq[QUO_BITS-1]};
      res = lane;
      if (t >= {1'b0, lane.dvs}) begin
         t = t - {1'b0, lane.dvs};
         res.numq = {lane.numq[QUO_BITS-2:0], 1'b1};
      end else begin
         res.numq = {lane.numq[QUO_BITS-2:0], 1'b0};
      end
      res.rem = t[DVS_BITS-1:0];
      return res;
   endfunction

   logic           valid_ff;
   rthsv_cell_type data_ff;
   rthsv_cell_type data_in;

   always_comb begin
      data_in.hue   = div_step(in_data.hue);
      data_in.sat   = div_step(in_data.sat);
      data_in.value = in_data.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_convert_core.sv =====
// top level of the rgb to hsv conversion pipeline
//
// Converts one 8-bit RGB pixel per clock into hue (1/64 degree), saturation
// (255 full scale) and value. The pipeline is a front stage, a row of 15
// divider cells that each resolve one quotient bit of the hue and saturation
// divisions, and an output register, with one item accepted per cycle while
// the result side does not stall.
// A stall on the result side while rsp_valid is high freezes the whole
// pipeline and is passed back to req_stall in the same cycle.
`default_nettype none

module rgb_to_hsv_convert_core
   import rthsv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire rthsv_req_type  req_item,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output rthsv_rsp_type       rsp_item
);

   logic           advance;
   logic           stage_valid [CELL_COUNT+1];
   rthsv_cell_type stage_data  [CELL_COUNT+1];
   logic           rsp_valid_ff;
   rthsv_rsp_type  rsp_item_ff;
   rthsv_rsp_type  rsp_item_in;
   rthsv_cell_type last;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   rthsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      rthsv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   always_comb begin
      last = stage_data[CELL_COUNT];
      // hue that rounds up to a full turn wraps to zero
      if (last.hue.numq >= HUE_FULL) begin
         rsp_item_in.hue = last.hue.numq - HUE_FULL;
      end else begin
         rsp_item_in.hue = last.hue.numq;
      end
      rsp_item_in.saturation = last.sat.numq[SAT_BITS-1:0];
      rsp_item_in.value      = last.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid[CELL_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   hue_range_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.hue < HUE_FULL)
      else $error("hue out of range");

   black_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.value == '0 |->
         rsp_item.saturation == '0 && rsp_item.hue == '0)
      else $error("black pixel with nonzero hue or saturation");

   grey_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.saturation == '0 |-> rsp_item.hue == '0)
      else $error("grey pixel with nonzero hue");

   freeze_check: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid[CELL_COUNT]) && $stable(stage_data[CELL_COUNT]))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== dv/tb_rgb_to_hsv_convert_core.sv =====
// testbench for the rgb to hsv core: predicted hue, saturation and value checked per item
`default_nettype none

module tb_rgb_to_hsv_convert_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rthsv_pkg::*;

   localparam longint HUE_SIXTH    = 3840;
   localparam longint HUE_TURN     = 23040;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     STALL_LIMIT  = 3000;
   localparam int     PHASE_ITEMS  = 435;

   localparam logic [23:0] CORNER_PX [22] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
      24'h010000, 24'h000100, 24'h000001, 24'h010100, 24'hFFFEFE, 24'hFEFFFF,
      24'h80FF7F, 24'h0001FF, 24'h020001, 24'h7F8080
   };

   typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} channel_type;
   typedef enum logic [2:0] {
      SHAPE_UNIFORM, SHAPE_GREY, SHAPE_TIE, SHAPE_EDGE, SHAPE_NEAR_GREY
   } pixel_shape_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   rthsv_req_type req_item  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rthsv_rsp_type rsp_item;

   rthsv_rsp_type hsv_expected_q [$];
   int            error_count    = 0;
   int            pixels_sent    = 0;
   int            results_seen   = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            quiet_cycles   = 0;

   rgb_to_hsv_convert_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   function automatic rthsv_rsp_type predict_hsv(input rthsv_req_type px);
      longint        r, g, b, mx, mn, d, num, sector, n, hue, sat;
      channel_type   top;
      rthsv_rsp_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      if (r >= g) begin
         top = CH_RED;
         mx  = r;
      end else begin
         top = CH_GREEN;
         mx  = g;
      end
      if (!(mx >= b)) begin
         top = CH_BLUE;
         mx  = b;
      end
      mn = (r <= g) ? r : g;
      if (!(mn <= b)) mn = b;
      d   = mx - mn;
      hue = 0;
      sat = 0;
      if (d > 0) begin
         case (top)
            CH_RED: begin
               sector = 0;
               num    = g - b;
            end
            CH_GREEN: begin
               sector = 2;
               num    = b - r;
            end
            default: begin
               sector = 4;
               num    = r - g;
            end
         endcase
         n = HUE_SIXTH * (sector * d + num);
         if (n < 0) n += HUE_TURN * d;
         hue = (2 * n + d) / (2 * d);
         if (hue >= HUE_TURN) hue -= HUE_TURN;
      end
      if (mx > 0) sat = (510 * d + mx) / (2 * mx);
      res.hue        = HUE_BITS'(hue);
      res.saturation = SAT_BITS'(sat);
      res.value      = CHAN_BITS'(mx);
      return res;
   endfunction

   function automatic rthsv_req_type random_pixel();
      rthsv_req_type   px;
      pixel_shape_type shape;
      logic [7:0]      v;
      int              pick;
      shape = pixel_shape_type'($urandom_range(0, 4));
      v     = 8'($urandom);
      px    = rthsv_req_type'(24'($urandom));
      case (shape)
         SHAPE_GREY: px = {v, v, v};
         SHAPE_TIE: begin
            case ($urandom_range(0, 2))
               0:       begin px.red   = v; px.green = v; end
               1:       begin px.green = v; px.blue  = v; end
               default: begin px.red   = v; px.blue  = v; end
            endcase
         end
         SHAPE_EDGE: begin
            pick      = $urandom_range(0, 3);
            px.red    = (pick < 2) ? 8'(pick) : 8'(252 + pick);
            pick      = $urandom_range(0, 3);
            px.green  = (pick < 2) ? 8'(pick) : 8'(252 + pick);
            pick      = $urandom_range(0, 3);
            px.blue   = (pick < 2) ? 8'(pick) : 8'(252 + pick);
         end
         SHAPE_NEAR_GREY: begin
            px.red   = v ^ 8'($urandom_range(0, 3));
            px.green = v ^ 8'($urandom_range(0, 3));
            px.blue  = v ^ 8'($urandom_range(0, 3));
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic send_pixel(input rthsv_req_type px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= px;
      do @(posedge clock); while (req_stall);
      hsv_expected_q.push_back(predict_hsv(px));
      pixels_sent++;
   endtask

   task automatic run_random_pixels(input int sender_pct, input int receiver_pct,
                                    input int count);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      repeat (count) send_pixel(random_pixel());
   endtask

   task automatic test_corner_pixels();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (CORNER_PX[i]) send_pixel(CORNER_PX[i]);
   endtask

   task automatic test_full_rate();
      run_random_pixels(0, 0, PHASE_ITEMS);
   endtask

   task automatic test_sender_gaps();
      run_random_pixels(70, 0, PHASE_ITEMS);
   endtask

   task automatic test_receiver_backpressure();
      run_random_pixels(0, 70, PHASE_ITEMS);
   endtask

   task automatic test_mixed_idling();
      run_random_pixels(23, 23, PHASE_ITEMS);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rthsv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (hsv_expected_q.size() == 0) begin
            $error("unexpected result: hue %0d saturation %0d value %0d",
                   rsp_item.hue, rsp_item.saturation, rsp_item.value);
            error_count++;
         end else begin
            want = hsv_expected_q.pop_front();
            if (rsp_item.hue !== want.hue) begin
               $error("hue mismatch: expected %0d, actual %0d", want.hue, rsp_item.hue);
               error_count++;
            end
            if (rsp_item.saturation !== want.saturation) begin
               $error("saturation mismatch: expected %0d, actual %0d",
                      want.saturation, rsp_item.saturation);
               error_count++;
            end
            if (rsp_item.value !== want.value) begin
               $error("value mismatch: expected %0d, actual %0d", want.value, rsp_item.value);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_pixels();
      test_full_rate();
      test_sender_gaps();
      test_receiver_backpressure();
      test_mixed_idling();
      req_valid <= 1'b0;
      while (hsv_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hsv_expected_q.size() != 0) begin
         $error("%0d results never arrived", hsv_expected_q.size());
         error_count++;
      end
      $display("sent %0d pixels (corners, greys, ties, edge values, random) and checked %0d results",
               pixels_sent, results_seen);
      $display("idle mixes: full rate, sender gaps, receiver backpressure, both sides idling");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
